[design/tedet_pkg.sv]
package tedet_pkg;

    typedef enum logic [2:0] {
        ENC_ANSI   = 3'd0,
        ENC_LE     = 3'd1,
        ENC_BE     = 3'd2,
        ENC_UTF8   = 3'd3,
        ENC_BINARY = 3'd4
    } t_enc_class;

    // UTF-8 sequence tracker state
    typedef struct packed {
        logic [1:0] pend;
        logic       broken;
        logic       seen;
    } t_scan;

    localparam logic [15:0] LIMIT_RESET = 16'd2;
    localparam logic [16:0] PAIR_MAX    = 17'h1FFFF;
    localparam logic [2:0]  COUNT_MAX   = 3'd7;
    localparam logic [2:0]  ZERO_THRESH = 3'd3;

    localparam logic [15:0] BOM_LE_HEAD  = 16'hFEFF;
    localparam logic [15:0] BOM_BE_HEAD  = 16'hFFFE;
    localparam logic [15:0] BOM_U8_HEAD  = 16'hBBEF;
    localparam logic [7:0]  BOM_U8_TAIL  = 8'hBF;

    function automatic t_scan scan_byte(input t_scan s, input logic [7:0] b);
        t_scan r;
        r = s;
        if (s.pend != 2'd0) begin
            if (b[7:6] != 2'b10) begin
                r.broken = 1'b1;
            end
            r.pend = s.pend - 2'd1;
        end else if (b[7:5] == 3'b110) begin
            r.pend = 2'd1;
            r.seen = 1'b1;
        end else if (b[7:4] == 4'b1110) begin
            r.pend = 2'd2;
            r.seen = 1'b1;
        end else if (b[7:3] == 5'b11110) begin
            r.pend = 2'd3;
            r.seen = 1'b1;
        end
        return r;
    endfunction

    function automatic logic is_illegal(input logic [7:0] b);
        return (b == 8'hC0) || (b == 8'hC1) || (b >= 8'hF5);
    endfunction

endpackage

[design/tedet_core.sv]
module tedet_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  logic [15:0]            i_limit,
    output tedet_pkg::t_enc_class  o_class
);

    logic [7:0]        r_rec [4];
    logic [23:0]       r_lead;
    logic [2:0]        r_early;
    logic              r_parity;
    logic [16:0]       r_pairs;
    logic [2:0]        r_zeros;
    logic              r_illegal;
    tedet_pkg::t_scan  r_scan;

    logic [7:0]        n_rec [4];
    logic [23:0]       n_lead;
    logic [2:0]        n_early;
    logic              n_parity;
    logic [16:0]       n_pairs;
    logic [2:0]        n_zeros;
    logic              n_illegal;
    tedet_pkg::t_scan  n_scan;
    tedet_pkg::t_scan  fin_scan;

    always_comb begin
        n_pairs   = r_pairs;
        n_zeros   = r_zeros;
        n_lead    = r_lead;
        n_illegal = r_illegal || tedet_pkg::is_illegal(i_byte);
        n_scan    = r_scan;

        // zero pair at an even position, completed before this byte
        if (r_early >= 3'd2 && !r_parity && r_rec[0] == 8'd0 && r_rec[1] == 8'd0
            && r_pairs != tedet_pkg::PAIR_MAX) begin
            n_pairs = r_pairs + 17'd1;
        end
        if (r_early >= 3'd2 && i_byte == 8'd0 && r_zeros != tedet_pkg::COUNT_MAX) begin
            n_zeros = r_zeros + 3'd1;
        end
        unique case (r_early)
            3'd0:    n_lead[7:0]   = i_byte;
            3'd1:    n_lead[15:8]  = i_byte;
            3'd2:    n_lead[23:16] = i_byte;
            default: n_lead        = r_lead;
        endcase
        // UTF-8 scan trails the input by four bytes
        if (r_early >= 3'd4) begin
            n_scan = tedet_pkg::scan_byte(r_scan, r_rec[3]);
        end

        n_rec[0] = i_byte;
        n_rec[1] = r_rec[0];
        n_rec[2] = r_rec[1];
        n_rec[3] = r_rec[2];
        n_early  = (r_early == tedet_pkg::COUNT_MAX) ? r_early : r_early + 3'd1;
        n_parity = ~r_parity;

        // flush owed continuations against the buffered tail
        fin_scan = n_scan;
        for (int k = 0; k < 3; k++) begin
            if (fin_scan.pend != 2'd0) begin
                fin_scan = tedet_pkg::scan_byte(fin_scan, n_rec[3-k]);
            end
        end

        priority if (n_early < 3'd2) begin
            o_class = tedet_pkg::ENC_ANSI;
        end else if (n_pairs > {1'b0, i_limit}) begin
            o_class = tedet_pkg::ENC_BINARY;
        end else if (n_lead[15:0] == tedet_pkg::BOM_LE_HEAD) begin
            o_class = tedet_pkg::ENC_LE;
        end else if (n_lead[15:0] == tedet_pkg::BOM_BE_HEAD) begin
            o_class = tedet_pkg::ENC_BE;
        end else if (n_zeros > tedet_pkg::ZERO_THRESH && !n_parity) begin
            o_class = tedet_pkg::ENC_LE;
        end else if (n_early < 3'd3) begin
            o_class = tedet_pkg::ENC_ANSI;
        end else if (n_lead[15:0] == tedet_pkg::BOM_U8_HEAD
                     && n_lead[23:16] == tedet_pkg::BOM_U8_TAIL) begin
            o_class = tedet_pkg::ENC_UTF8;
        end else if (n_illegal || fin_scan.broken) begin
            o_class = tedet_pkg::ENC_ANSI;
        end else begin
            o_class = fin_scan.seen ? tedet_pkg::ENC_UTF8 : tedet_pkg::ENC_ANSI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            for (int k = 0; k < 4; k++) begin
                r_rec[k] <= 8'd0;
            end
            r_lead    <= '0;
            r_early   <= '0;
            r_parity  <= 1'b0;
            r_pairs   <= '0;
            r_zeros   <= '0;
            r_illegal <= 1'b0;
            r_scan    <= '0;
        end else if (i_step) begin
            r_rec     <= n_rec;
            r_lead    <= n_lead;
            r_early   <= n_early;
            r_parity  <= n_parity;
            r_pairs   <= n_pairs;
            r_zeros   <= n_zeros;
            r_illegal <= n_illegal;
            r_scan    <= n_scan;
        end
    end

endmodule

[design/text_encoding_detector_top.sv]
// Byte-stream text encoding classifier. One byte word is accepted per clock;
// the block sustains one byte per cycle as long as results are drained. Each
// byte passes an input register; for the byte flagged with tlast, the class
// computed from the updated per-buffer state is captured in the output
// register that holds the result word. Only that last byte yields a result
// (0 ANSI, 1 UTF-16 LE, 2 UTF-16 BE, 3 UTF-8, 4 binary); all buffer state then
// clears. A last byte waits in the input register only while an earlier result
// is still held. The user must write the null pair limit through the config
// channel only while no buffer is in progress; the block does not enforce it.
module text_encoding_detector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // null_pair_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [2:0] encoding_class, [7:3] zero
);

    logic [15:0]           r_limit;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic                  r_out_valid;
    tedet_pkg::t_enc_class r_out_class;
    tedet_pkg::t_enc_class core_class;
    logic                  step;

    assign o_cfg_ready = 1'b1;

    // non-last bytes never wait on the result side
    assign step = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tedet_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    tedet_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_limit (r_limit),
        .o_class (core_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out_class <= core_class;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_class};

endmodule
